>>> hw/rtl/double_ended_queue_core_defines.svh
// Assertion macros used by the queue checker.
// Both expect clk_i and rst_ni in the scope of the use.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is held
`define DEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held
`define DEQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/deq_pkg.sv
package deq_pkg;

  // Operation codes carried by a request word
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  // Status codes carried by a response word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

>>> hw/rtl/deq_if.sv
// Request channel: one operation per word
interface deq_req_if #(
  parameter int DataWidth = 32
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           op;
  logic [DataWidth-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

// Response channel: one word per operation
interface deq_rsp_if #(
  parameter int DataWidth  = 32,
  parameter int CountWidth = 5
);
  logic                  valid;
  logic                  ready;
  logic [DataWidth-1:0]  popped;
  logic [1:0]            status;
  logic [DataWidth-1:0]  front_value;
  logic [DataWidth-1:0]  back_value;
  logic [CountWidth-1:0] element_count;

  modport source (output valid, popped, status, front_value, back_value, element_count,
                  input ready);
  modport sink   (input valid, popped, status, front_value, back_value, element_count,
                  output ready);
endinterface

>>> hw/rtl/deq_ram.sv
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> hw/rtl/double_ended_queue_core.sv
// One operation at a time: an accepted request word moves the block to its fetch
// state, where the slot memory's registered read refills the cached front or back
// after a pop; the response word is registered once the output register is free.
// Reset clears the head pointer, the count and all valid flags; the slot
// memory is not cleared, and entries are read only after they have been written.
module double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_FRONT,
    FILL_BACK
  } fill_e;

  // Fold a sum of ring positions back into the ring
  function automatic logic [AW-1:0] wrap(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= PW'(DEPTH)) ? (p - PW'(DEPTH)) : p;
    return r[AW-1:0];
  endfunction

  logic                  state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  status_e               status_q, status_d;
  fill_e                 fill_q, fill_d;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_popped_q, out_front_q, out_back_q;
  logic [1:0]            out_status_q;
  logic [CW-1:0]         out_count_q;

  logic                  accept, out_free, finish;
  logic                  full, empty;
  logic [PW-1:0]         sum_ht;
  logic [AW-1:0]         tail_pos, prev_back_pos, next_head, dec_head;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] new_front, new_back;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign finish   = (state_q == S_FETCH) && out_free;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // Ring positions around the stored range
  assign sum_ht        = PW'(head_q) + PW'(count_q);
  assign tail_pos      = wrap(sum_ht);
  assign prev_back_pos = wrap(sum_ht - PW'(2));
  assign next_head     = wrap(PW'(head_q) + PW'(1));
  assign dec_head      = (head_q == '0) ? AW'(DEPTH - 1) : (head_q - AW'(1));

  // Decode the operation: pointer update, memory access and cached ends
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    front_d  = front_q;
    back_d   = back_q;
    popped_d = popped_q;
    status_d = status_q;
    fill_d   = fill_q;
    wr_en    = 1'b0;
    wr_addr  = tail_pos;
    rd_en    = 1'b0;
    rd_addr  = next_head;

    if (accept) begin
      popped_d = '0;
      status_d = ST_OK;
      fill_d   = FILL_NONE;
      unique case (req_i.op)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = tail_pos;
            count_d = count_q + CW'(1);
            back_d  = req_i.value;
            if (empty) begin
              front_d = req_i.value;
            end
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = dec_head;
            head_d  = dec_head;
            count_d = count_q + CW'(1);
            front_d = req_i.value;
            if (empty) begin
              back_d = req_i.value;
            end
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            popped_d = back_q;
            count_d  = count_q - CW'(1);
            if (count_q > CW'(1)) begin
              rd_en   = 1'b1;
              rd_addr = prev_back_pos;
              fill_d  = FILL_BACK;
            end
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            popped_d = front_q;
            head_d   = next_head;
            count_d  = count_q - CW'(1);
            if (count_q > CW'(1)) begin
              rd_en   = 1'b1;
              rd_addr = next_head;
              fill_d  = FILL_FRONT;
            end
          end
        end
        OP_CLEAR: begin
          head_d  = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end

    // Refill the cached end from the memory read
    if (finish) begin
      front_d = new_front;
      back_d  = new_back;
    end
  end

  assign new_front = (fill_q == FILL_FRONT) ? rd_data : front_q;
  assign new_back  = (fill_q == FILL_BACK)  ? rd_data : back_q;

  // Advance the two-step sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_FETCH;
      S_FETCH: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = finish || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      fill_q      <= FILL_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the cached ends and the per-operation results
  always_ff @(posedge clk_i) begin
    front_q  <= front_d;
    back_q   <= back_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

  // Load the response word; empty queues show zero at both ends
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_popped_q <= popped_q;
      out_status_q <= status_q;
      out_front_q  <= empty ? '0 : new_front;
      out_back_q   <= empty ? '0 : new_back;
      out_count_q  <= count_q;
    end
  end

  deq_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_deq_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (req_i.value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.popped        = out_popped_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.front_value   = out_front_q;
  assign rsp_o.back_value    = out_back_q;
  assign rsp_o.element_count = out_count_q;

endmodule

>>> hw/rtl/deq_checker.sv
`include "double_ended_queue_core_defines.svh"

module deq_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [DATA_WIDTH-1:0]         rsp_popped_i,
  input logic [1:0]                    rsp_status_i,
  input logic [DATA_WIDTH-1:0]         rsp_front_i,
  input logic [DATA_WIDTH-1:0]         rsp_back_i,
  input logic [$clog2(DEPTH+1)-1:0]    rsp_count_i
);
  import deq_pkg::*;

  localparam int CountWidth = $clog2(DEPTH + 1);

  logic                                req_fire, rsp_stall;
  logic [3*DATA_WIDTH+CountWidth-1:0]  rsp_word;
  logic                                count_ok, empty_rsp, empty_clean, full_rsp, at_capacity;

  // Gather the handshake and payload views used below
  assign req_fire    = req_valid_i && req_ready_i;
  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_word    = {rsp_popped_i, rsp_front_i, rsp_back_i, rsp_count_i};
  assign count_ok    = (rsp_count_i <= CountWidth'(DEPTH));
  assign empty_rsp   = rsp_valid_i && (rsp_status_i == ST_EMPTY);
  assign empty_clean = (rsp_popped_i == '0) && (rsp_count_i == '0) &&
                       (rsp_front_i == '0) && (rsp_back_i == '0);
  assign full_rsp    = rsp_valid_i && (rsp_status_i == ST_FULL);
  assign at_capacity = (rsp_count_i == CountWidth'(DEPTH));

  // One operation in flight: ready drops in the fetch state
  `DEQ_ASSERT_NXT(a_busy, req_fire, !req_ready_i, "ready high after accept")

  // A stalled response word holds
  `DEQ_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid_i && $stable(rsp_word), "stalled word changed")

  // Count never exceeds capacity
  `DEQ_ASSERT_IMP(a_count_range, rsp_valid_i, count_ok, "element count above capacity")

  // A failed pop removes nothing from an empty queue
  `DEQ_ASSERT_IMP(a_empty_pop, empty_rsp, empty_clean, "pop on empty reported data")

  // A refused push only happens at capacity
  `DEQ_ASSERT_IMP(a_full_push, full_rsp, at_capacity, "full status below capacity")

endmodule

bind double_ended_queue_core deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_popped_i(rsp_o.popped),
  .rsp_status_i(rsp_o.status),
  .rsp_front_i (rsp_o.front_value),
  .rsp_back_i  (rsp_o.back_value),
  .rsp_count_i (rsp_o.element_count)
);

>>> sim/deq_checker.sv
`timescale 1ns / 100ps

module deq_scoreboard #(
  parameter int Depth      = 16,
  parameter int DataWidth  = 32,
  parameter int CountWidth = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if        req_i,
  deq_rsp_if        rsp_i,
  output int        fail_count_o,
  output int        pending_o
);
  import deq_pkg::*;

  localparam int AddrWidth = $clog2(Depth);

  typedef struct packed {
    logic [DataWidth-1:0]  popped;
    status_e               status;
    logic [DataWidth-1:0]  front_value;
    logic [DataWidth-1:0]  back_value;
    logic [CountWidth-1:0] element_count;
  } rsp_word_t;

  // Shadow copy of the ring: slots, front position and fill level
  logic [DataWidth-1:0]  ring_q [Depth];
  logic [AddrWidth-1:0]  head_q;
  logic [CountWidth-1:0] count_q;

  // Response words owed by the block, oldest first
  rsp_word_t             due_q [$];

  // Ring position lying offset places after the front
  function automatic int ring_slot(int offset);
    return (int'(head_q) + offset) % Depth;
  endfunction

  // Apply one operation to the shadow ring and build the response word it owes
  function automatic rsp_word_t apply_op(logic [2:0] op, logic [DataWidth-1:0] value);
    rsp_word_t w;
    w = '0;
    w.status = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (count_q >= Depth) begin
          w.status = ST_FULL;
        end else begin
          ring_q[ring_slot(int'(count_q))] = value;
          count_q = count_q + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (count_q >= Depth) begin
          w.status = ST_FULL;
        end else begin
          head_q = (head_q == '0) ? AddrWidth'(Depth - 1) : head_q - 1'b1;
          ring_q[head_q] = value;
          count_q = count_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count_q == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.popped = ring_q[ring_slot(int'(count_q) - 1)];
          count_q = count_q - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count_q == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.popped = ring_q[head_q];
          head_q = AddrWidth'(ring_slot(1));
          count_q = count_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        head_q = '0;
        count_q = '0;
      end
      default: begin
        // spare codes behave as no operation
      end
    endcase
    // Report the ends only while something is stored
    if (count_q != 0) begin
      w.front_value = ring_q[head_q];
      w.back_value = ring_q[ring_slot(int'(count_q) - 1)];
    end
    w.element_count = count_q;
    return w;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endfunction

  // Predict on every accepted request word, compare every accepted response word
  always @(posedge clk_i) begin
    rsp_word_t want;
    if (!rst_ni) begin
      head_q = '0;
      count_q = '0;
      due_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        due_q.insert(due_q.size(), apply_op(req_i.op, req_i.value));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_q.size() == 0) begin
          $error("response word with no request outstanding");
          fail_count_o++;
        end else begin
          want = due_q[0];
          due_q.delete(0);
          check_field("popped", want.popped, rsp_i.popped);
          check_field("status", want.status, rsp_i.status);
          check_field("front_value", want.front_value, rsp_i.front_value);
          check_field("back_value", want.back_value, rsp_i.back_value);
          check_field("element_count", want.element_count, rsp_i.element_count);
        end
      end
    end
    pending_o <= due_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import deq_pkg::*;

  localparam int Depth      = 16;
  localparam int DataWidth  = 32;
  localparam int CountWidth = 5;

  // Codes outside the defined set; the block treats them as no operation
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RandomOps     = 450;
  localparam int QuietOps      = 60;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 10;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_pct = 20;
  bit   quiet = 1'b0;

  deq_req_if #(.DataWidth(DataWidth)) req_if ();
  deq_rsp_if #(.DataWidth(DataWidth), .CountWidth(CountWidth)) rsp_if ();

  double_ended_queue_core #(
    .DEPTH      (Depth),
    .DATA_WIDTH (DataWidth)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  deq_scoreboard #(
    .Depth      (Depth),
    .DataWidth  (DataWidth),
    .CountWidth (CountWidth)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Periodically change how busy the idling is, calm stretches included
  initial begin
    forever begin
      repeat (48) @(negedge clk);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
    end
  end

  // Stall the response side in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Abort when no word moves on either channel for too long
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one request word, after an optional gap, and hold it until taken
  task automatic send_word(input logic [2:0] op, input logic [DataWidth-1:0] value);
    int gap;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.value <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Hold off the request side until every owed response word has come back
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DataWidth'($urandom);
    endcase
  endfunction

  initial begin
    int push_pct;
    int r;
    logic [2:0] op;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OP_NONE;
    req_if.value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, idle and spare codes
    send_word(OP_POP_BACK, pick_value());
    send_word(OP_POP_FRONT, pick_value());
    send_word(OP_NONE, '1);
    send_word(OP_SPARE_LO, '1);
    send_word(OP_SPARE_HI, '0);
    // Directed: front push wraps the head, then the last element leaves by either end
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_POP_BACK, '0);
    send_word(OP_PUSH_BACK, '0);
    send_word(OP_POP_FRONT, '1);
    // Directed: fill from both ends, push on full, then clear
    for (int k = 0; k < Depth; k++) begin
      send_word((k % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
    end
    send_word(OP_PUSH_FRONT, pick_value());
    send_word(OP_CLEAR, pick_value());
    wait_drained();

    // Random: phases leaning towards filling, draining or neither
    push_pct = 50;
    for (int i = 0; i < RandomOps; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      if (i == 150 || i == 300) wait_drained();
      if (i >= RandomOps - QuietOps) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_CLEAR;
      end else if (r < 5) begin
        op = OP_NONE;
      end else if (r < 7) begin
        op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      send_word(op, pick_value());
    end

    // Let every owed word arrive, then allow for stragglers
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
